>>> rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
`default_nettype none
package lkvc_pkg;

  // Width of the capacity register.
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Action codes carried in the input tuser bit.
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // Broadcast controls from the sequencer to every cell of the chain.
  typedef struct packed {
    logic look;  // compare the stored key against the command key
    logic upd;   // shift or load cells at or below the update position
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> rtl/lru_key_value_cache_top.sv
// Top level of the LRU key/value cache: sequencer, chain of recency cells, result register.
//
// Input words arrive on s_tvalid/s_tready with the key and put value in s_tdata and the
// action (get or put) in s_tuser. Each input word yields exactly one result word on
// m_tvalid/m_tready: hit and evicted flags in m_tuser, read value and evicted key in m_tdata.
// The capacity register is written through cfg_valid/cfg_ready/cfg_data, and the user
// must write it only while the cache is idle; the block itself does not enforce this.
// cfg_ready is always high. Entries sit in a chain of cells ordered by recency, cell 0
// the most recent. A word passes through accept, key compare in every cell, hit/victim
// selection, then one shift of the chain that moves the hit or new entry to the front
// (no shift on a get miss). The result word is registered at the shift, and the next
// word is accepted only once that shift is done.
// Reset empties the cache (all cells invalid, count zero) and sets capacity to 16.
// While a result waits on m_tready the next word is still accepted and processed up to
// the final shift, which holds until the result register frees up.
`default_nettype none
module lru_key_value_cache_top #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [63:0] s_tdata,   // [31:0] lookup_key, [63:32] put_value
  input  wire  [0:0]  s_tuser,   // [0] action
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [63:0] m_tdata,   // [31:0] read_value, [63:32] evicted_key
  output logic [1:0]  m_tuser,   // [0] hit, [1] evicted
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [4:0]  cfg_data   // [4:0] capacity
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_SEL  = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0]                 state;
  logic [lkvc_pkg::CAP_W-1:0] capacity;
  logic [CNT_W-1:0]           count;

  logic                       cmd_action;
  logic [KEY_BITS-1:0]        cmd_key;
  logic [VALUE_BITS-1:0]      cmd_value;

  // Registered results of the selection step.
  logic                       sel_hit;
  logic                       sel_write;
  logic                       sel_grow;
  logic [IDX_W-1:0]           sel_pos;
  logic [VALUE_BITS-1:0]      sel_val;
  logic                       res_ev;
  logic [31:0]                res_rd;
  logic [31:0]                res_evk;

  logic                       out_free;
  logic                       upd_go;
  lkvc_pkg::cell_ctl_t        ctl;

  logic                       cell_valid [ENTRIES];
  logic [KEY_BITS-1:0]        cell_key   [ENTRIES];
  logic [VALUE_BITS-1:0]      cell_value [ENTRIES];
  logic [ENTRIES-1:0]         match_vec;
  logic [ENTRIES:0]           valid_ext;

  logic                       front_valid;
  logic [VALUE_BITS-1:0]      front_value;

  // Selection logic over the registered compare results.
  logic                       hit_any;
  logic [IDX_W-1:0]           hit_pos;
  logic [VALUE_BITS-1:0]      hit_val;
  logic [KEY_BITS-1:0]        last_key;
  logic [CMP_W-1:0]           cap_ext;
  logic [CMP_W-1:0]           eff_cap;
  logic                       full;
  logic                       is_put;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign upd_go    = (state == ST_UPD) && out_free;
  assign ctl.look  = (state == ST_LOOK);
  assign ctl.upd   = upd_go && sel_write;

  assign front_valid = 1'b1;
  assign front_value = (cmd_action == lkvc_pkg::ACT_PUT) ? cmd_value : sel_val;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_front
        lkvc_cell #(
          .IDX(g), .IDX_W(IDX_W), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
        ) u_cell (
          .clk        (clk),
          .rst        (rst),
          .ctl        (ctl),
          .pos        (sel_pos),
          .cmp_key    (cmd_key),
          .prev_valid (front_valid),
          .prev_key   (cmd_key),
          .prev_value (front_value),
          .valid      (cell_valid[g]),
          .key        (cell_key[g]),
          .value      (cell_value[g]),
          .match      (match_vec[g])
        );
      end else begin : g_rest
        lkvc_cell #(
          .IDX(g), .IDX_W(IDX_W), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
        ) u_cell (
          .clk        (clk),
          .rst        (rst),
          .ctl        (ctl),
          .pos        (sel_pos),
          .cmp_key    (cmd_key),
          .prev_valid (cell_valid[g-1]),
          .prev_key   (cell_key[g-1]),
          .prev_value (cell_value[g-1]),
          .valid      (cell_valid[g]),
          .key        (cell_key[g]),
          .value      (cell_value[g]),
          .match      (match_vec[g])
        );
      end
      assign valid_ext[g] = cell_valid[g];
    end
  endgenerate

  assign valid_ext[ENTRIES] = 1'b0;

  // Valid cells form a prefix, so the last valid cell holds the least recent entry.
  always_comb begin
    hit_pos  = '0;
    hit_val  = '0;
    last_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_vec[i]) begin
        hit_pos = hit_pos | IDX_W'(i);
        hit_val = hit_val | cell_value[i];
      end
      if (valid_ext[i] && !valid_ext[i+1]) begin
        last_key = last_key | cell_key[i];
      end
    end
  end

  assign hit_any = |match_vec;
  assign is_put  = (cmd_action == lkvc_pkg::ACT_PUT);
  assign cap_ext = CMP_W'(capacity);

  always_comb begin
    priority if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full = (CMP_W'(count) >= eff_cap);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      capacity <= lkvc_pkg::CAP_RESET;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state <= ST_SEL;
        end
        ST_SEL: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (upd_go) begin
        m_tvalid <= 1'b1;
        if (sel_grow) begin
          count <= count + 1'b1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Command capture, selection results and result word.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd_action <= s_tuser[0];
      cmd_key    <= KEY_BITS'(s_tdata[31:0]);
      cmd_value  <= VALUE_BITS'(s_tdata[63:32]);
    end
    if (state == ST_SEL) begin
      sel_hit   <= hit_any;
      sel_val   <= hit_val;
      sel_write <= hit_any || is_put;
      sel_grow  <= !hit_any && is_put && !full;
      res_ev    <= !hit_any && is_put && full;
      res_rd    <= (hit_any && !is_put) ? 32'(hit_val) : 32'd0;
      res_evk   <= (!hit_any && is_put && full) ? 32'(last_key) : 32'd0;
      priority if (hit_any) begin
        sel_pos <= hit_pos;
      end else if (full) begin
        sel_pos <= IDX_W'(count - 1'b1);
      end else begin
        sel_pos <= IDX_W'(count);
      end
    end
    if (upd_go) begin
      m_tdata <= {res_evk, res_rd};
      m_tuser <= {res_ev, sel_hit};
    end
  end

`ifndef SYNTHESIS
  // Only one word is processed at a time: acceptance closes the input until its result is issued.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a word is in flight");

  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("entry count beyond cell count");

  // Keys are unique across valid cells.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEL) |-> $onehot0(match_vec))
    else $error("key present in more than one cell");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> !m_tuser[0])
    else $error("eviction reported on a hit");
`endif

endmodule
`default_nettype wire

>>> rtl/lkvc_cell.sv
// One recency slot of the LRU chain: holds an entry, compares its key, takes its neighbor's entry.
`default_nettype none
module lkvc_cell #(
  parameter int IDX        = 0,
  parameter int IDX_W      = 4,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire                        clk,
  input  wire                        rst,
  input  lkvc_pkg::cell_ctl_t        ctl,
  input  wire  [IDX_W-1:0]           pos,
  input  wire  [KEY_BITS-1:0]        cmp_key,
  input  wire                        prev_valid,
  input  wire  [KEY_BITS-1:0]        prev_key,
  input  wire  [VALUE_BITS-1:0]      prev_value,
  output logic                       valid,
  output logic [KEY_BITS-1:0]        key,
  output logic [VALUE_BITS-1:0]      value,
  output logic                       match
);

  logic take;

  // Cells from the front down to the update position take their upper neighbor's entry.
  assign take = ctl.upd && (IDX_W'(IDX) <= pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctl.look) begin
        match <= valid && (key == cmp_key);
      end
      if (take) begin
        valid <= prev_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key   <= prev_key;
      value <= prev_value;
    end
  end

endmodule
`default_nettype wire

>>> test/lkvc_lru_checker.sv
// Checker for the LRU key/value cache: tracks requests, predicts replies, compares them.
module lkvc_lru_checker #(
  parameter int ENTRIES = 16
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         s_tvalid,
  input  wire                         s_tready,
  input  wire  [63:0]                 s_tdata,   // [31:0] lookup_key, [63:32] put_value
  input  wire  [0:0]                  s_tuser,   // [0] action
  input  wire                         m_tvalid,
  input  wire                         m_tready,
  input  wire  [63:0]                 m_tdata,   // [31:0] read_value, [63:32] evicted_key
  input  wire  [1:0]                  m_tuser,   // [0] hit, [1] evicted
  input  wire                         cfg_valid,
  input  wire                         cfg_ready,
  input  wire  [lkvc_pkg::CAP_W-1:0]  cfg_data,  // [4:0] capacity
  output int                          mismatches,
  output int                          awaited,
  output int                          replies,
  output int                          hits,
  output int                          evictions
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } cache_reply_t;

  // Shadow copy of the cache contents, kept per slot with an age rank (0 = newest).
  logic                       slot_used [ENTRIES];
  logic [31:0]                slot_key  [ENTRIES];
  logic [31:0]                slot_val  [ENTRIES];
  int unsigned                slot_age  [ENTRIES];
  int unsigned                live_count;
  logic [lkvc_pkg::CAP_W-1:0] cap_reg;

  cache_reply_t awaited_replies [$];
  int bad_cnt, reply_cnt, hit_cnt, evict_cnt;

  // Age every live entry younger than the limit by one and make slot s the newest.
  function automatic void make_newest(int s, int unsigned limit);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_used[i] && i != s && slot_age[i] < limit) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function automatic cache_reply_t lru_access(logic act, logic [31:0] key, logic [31:0] val);
    cache_reply_t r;
    int found;
    int victim;
    int unsigned oldest;
    int unsigned limit;
    r = '0;
    found = -1;
    victim = -1;
    oldest = 0;
    for (int i = 0; i < ENTRIES; i++)
      if (found < 0 && slot_used[i] && slot_key[i] == key) found = i;
    if (found >= 0) begin
      r.hit = 1'b1;
      if (act == lkvc_pkg::ACT_PUT) slot_val[found] = val;
      else r.read_value = slot_val[found];
      make_newest(found, slot_age[found]);
    end else if (act == lkvc_pkg::ACT_PUT) begin
      // zero acts as one, anything above the slot count as the slot count
      limit = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : cap_reg);
      if (live_count >= limit) begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot_used[i] && (victim < 0 || slot_age[i] >= oldest)) begin
            victim = i;
            oldest = slot_age[i];
          end
        if (victim >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = slot_key[victim];
          slot_used[victim] = 1'b0;
          live_count--;
        end
      end
      if (victim < 0)
        for (int i = 0; i < ENTRIES; i++)
          if (victim < 0 && !slot_used[i]) victim = i;
      if (victim >= 0) begin
        slot_used[victim] = 1'b1;
        slot_key[victim] = key;
        slot_val[victim] = val;
        live_count++;
        make_newest(victim, ENTRIES);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    cache_reply_t got;
    cache_reply_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_used[i] = 1'b0;
        slot_age[i] = 0;
      end
      live_count = 0;
      cap_reg = lkvc_pkg::CAP_RESET;
      awaited_replies.delete();
      bad_cnt = 0;
      reply_cnt = 0;
      hit_cnt = 0;
      evict_cnt = 0;
    end else begin
      if (cfg_valid && cfg_ready) cap_reg = cfg_data;
      // Check the outgoing word before queuing the new one.
      if (m_tvalid && m_tready) begin
        got.hit = m_tuser[0];
        got.evicted = m_tuser[1];
        got.read_value = m_tdata[31:0];
        got.evicted_key = m_tdata[63:32];
        reply_cnt++;
        if (awaited_replies.size() == 0) begin
          if (bad_cnt < 10)
            $display("%0t: reply word with nothing outstanding: %s",
                     $realtime,
                     $sformatf("hit=%0d value=%h evicted=%0d key=%h",
                               got.hit, got.read_value, got.evicted, got.evicted_key));
          bad_cnt++;
        end else begin
          want = awaited_replies.pop_front();
          if (got.hit !== want.hit || got.read_value !== want.read_value ||
              got.evicted !== want.evicted || got.evicted_key !== want.evicted_key) begin
            if (bad_cnt < 10) begin
              $display("%0t: reply %0d wrong: expected hit=%0d value=%h evicted=%0d key=%h,",
                       $realtime, reply_cnt, want.hit, want.read_value, want.evicted,
                       want.evicted_key);
              $display("    got hit=%0d value=%h evicted=%0d key=%h",
                       got.hit, got.read_value, got.evicted, got.evicted_key);
            end
            bad_cnt++;
          end
          if (want.hit) hit_cnt++;
          if (want.evicted) evict_cnt++;
        end
      end
      if (s_tvalid && s_tready)
        awaited_replies.push_back(lru_access(s_tuser[0], s_tdata[31:0], s_tdata[63:32]));
    end
    mismatches <= bad_cnt;
    awaited    <= awaited_replies.size();
    replies    <= reply_cnt;
    hits       <= hit_cnt;
    evictions  <= evict_cnt;
  end

endmodule

>>> test/tb.sv
// Testbench top for the LRU key/value cache: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_OFF_CYCLES = 80;
  localparam int QUIET_LIMIT     = 2000;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [63:0]                s_tdata = '0;   // [31:0] lookup_key, [63:32] put_value
  logic [0:0]                 s_tuser = '0;   // [0] action
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [63:0]                m_tdata;        // [31:0] read_value, [63:32] evicted_key
  logic [1:0]                 m_tuser;        // [0] hit, [1] evicted
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [lkvc_pkg::CAP_W-1:0] cfg_data = '0;  // [4:0] capacity

  int mismatches, awaited, replies, hits, evictions;
  int words_sent = 0;
  int cap_writes = 0;
  int hold_asks = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet = 0;
  logic calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lru_key_value_cache_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  lkvc_lru_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .awaited   (awaited),
    .replies   (replies),
    .hits      (hits),
    .evictions (evictions)
  );

  // Reply side: random back-pressure, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asks) begin
      hold_served <= hold_served + 1;
      hold_left <= HOLD_OFF_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 16);
    end
  end

  // Abort when no channel has moved a word for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_word(logic act, logic [31:0] key, logic [31:0] val);
    while (!calm && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {val, key};
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  // Hold the request side until every reply is back, then let the pipeline empty.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(logic [lkvc_pkg::CAP_W-1:0] cap);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  // Keys mostly come from a small pool so that hits, updates and evictions recur.
  task automatic random_phase(int n_words, int pool_n, int hold_at, int drain_at);
    logic [31:0] pool [32];
    logic [31:0] key;
    logic        act;
    int          i;
    for (i = 0; i < 32; i++) pool[i] = $urandom;
    for (i = 0; i < n_words; i++) begin
      if (i == hold_at) hold_asks++;
      if (i == drain_at) settle();
      act = 1'($urandom_range(1));
      key = ($urandom_range(99) < 88) ? pool[$urandom_range(pool_n - 1)] : $urandom;
      send_word(act ? lkvc_pkg::ACT_PUT : lkvc_pkg::ACT_GET, key, $urandom);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty miss, extreme keys and values, oldest/newest promotion,
    // update in place, eviction, then capacity dropped below the fill level.
    set_capacity(5'd3);
    send_word(lkvc_pkg::ACT_GET, 32'h0000_0000, 32'h0000_1234);
    send_word(lkvc_pkg::ACT_PUT, 32'h0000_0000, 32'h0000_0000);
    send_word(lkvc_pkg::ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(lkvc_pkg::ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(lkvc_pkg::ACT_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(lkvc_pkg::ACT_PUT, 32'h0000_0005, 32'hA5A5_A5A5);
    send_word(lkvc_pkg::ACT_GET, 32'h0000_0005, 32'h0000_0000);
    send_word(lkvc_pkg::ACT_PUT, 32'h0000_0000, 32'h1234_5678);
    send_word(lkvc_pkg::ACT_PUT, 32'h0000_0007, 32'h0000_0077);
    send_word(lkvc_pkg::ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(lkvc_pkg::ACT_PUT, 32'h8000_0000, 32'h5555_5555);
    send_word(lkvc_pkg::ACT_GET, 32'h0000_0000, 32'h0000_0000);
    set_capacity(5'd1);
    send_word(lkvc_pkg::ACT_PUT, 32'h0000_0001, 32'h0000_0001);
    send_word(lkvc_pkg::ACT_GET, 32'h8000_0000, 32'h0000_0000);
    send_word(lkvc_pkg::ACT_PUT, 32'h0000_0002, 32'h0000_0002);
    send_word(lkvc_pkg::ACT_PUT, 32'h8000_0000, 32'h0000_0000);
    send_word(lkvc_pkg::ACT_GET, 32'h0000_0007, 32'h0000_0000);

    set_capacity(5'd16);
    random_phase(100, 24, 30, 60);
    set_capacity(5'd0);
    random_phase(60, 3, -1, -1);
    calm = 1'b1;
    set_capacity(5'd31);
    random_phase(80, 20, -1, -1);
    calm = 1'b0;
    set_capacity(5'd17);
    random_phase(60, 12, -1, -1);
    set_capacity(5'd5);
    random_phase(80, 10, 40, -1);
    set_capacity(lkvc_pkg::CAP_W'($urandom_range(31)));
    random_phase(90, $urandom_range(32, 4), -1, -1);
    set_capacity(5'd2);
    random_phase(80, 4, -1, -1);

    settle();
    repeat (16) @(posedge clk);
    $display("covered %0d get/put words across %0d capacity settings, incl. 0, 1, 16 and 31",
             words_sent, cap_writes);
    $display("checked %0d replies: %0d hits, %0d evictions", replies, hits, evictions);
    if (mismatches == 0 && awaited == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
